// ----- hw/rtl/lge_pkg.sv -----
// ----------------------------------------------------------------------------
// lge_pkg
// Shared types and constants for the life grid generation engine.
// ----------------------------------------------------------------------------
package lge_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam int AREA_W   = 7;
    localparam int CFG_IDX_W = 1;
    localparam int GEN_W    = 32;

    localparam logic [AREA_W-1:0] ROWS_RESET = 7'd50;
    localparam logic [AREA_W-1:0] COLS_RESET = 7'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COLS = 1'b1;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] row;
        logic [5:0] col;
        logic       cell_in;
    } lge_req_t;

    typedef struct packed {
        logic             cell_out;
        logic [GEN_W-1:0] generation;
    } lge_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WR_WAIT,
        S_RD_WAIT,
        S_ADV,
        S_FINISH
    } lge_state_t;

    typedef struct packed {
        logic capture;
        logic rd_req;
        logic wr_cell;
        logic cap_cell;
        logic adv_start;
        logic adv_step;
        logic gen_inc;
        logic rsp_load;
    } lge_ctrl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       in_area;
        logic       rows_zero;
        logic       adv_last;
        logic       rsp_free;
    } lge_stat_t;

endpackage

// ----- hw/rtl/lge_ram.sv -----
// ----------------------------------------------------------------------------
// lge_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lge_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/lge_ctrl.sv -----
// ----------------------------------------------------------------------------
// lge_ctrl
// Command sequencer: accepts an item, runs its memory steps, posts the result.
// ----------------------------------------------------------------------------
module lge_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  lge_pkg::lge_stat_t stat,
    output lge_pkg::lge_ctrl_t ctrl
);

    lge_pkg::lge_state_t state_reg;
    lge_pkg::lge_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lge_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lge_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lge_pkg::S_DISPATCH;
                end
            end
            lge_pkg::S_DISPATCH:
            begin
                case (stat.cmd)
                    lge_pkg::CMD_WRITE:
                        state_next = stat.in_area ? lge_pkg::S_WR_WAIT : lge_pkg::S_FINISH;
                    lge_pkg::CMD_READ:
                        state_next = stat.in_area ? lge_pkg::S_RD_WAIT : lge_pkg::S_FINISH;
                    lge_pkg::CMD_ADVANCE:
                        state_next = stat.rows_zero ? lge_pkg::S_FINISH : lge_pkg::S_ADV;
                    default:
                        state_next = lge_pkg::S_FINISH;
                endcase
            end
            lge_pkg::S_WR_WAIT:
            begin
                state_next = lge_pkg::S_FINISH;
            end
            lge_pkg::S_RD_WAIT:
            begin
                state_next = lge_pkg::S_FINISH;
            end
            lge_pkg::S_ADV:
            begin
                if (stat.adv_last)
                begin
                    state_next = lge_pkg::S_FINISH;
                end
            end
            lge_pkg::S_FINISH:
            begin
                if (stat.rsp_free)
                begin
                    state_next = lge_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lge_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            lge_pkg::S_IDLE:
            begin
                req_stall    = 1'b0;
                ctrl.capture = req_valid;
            end
            lge_pkg::S_DISPATCH:
            begin
                case (stat.cmd) inside
                    lge_pkg::CMD_WRITE,
                    lge_pkg::CMD_READ:
                        ctrl.rd_req = stat.in_area;
                    lge_pkg::CMD_ADVANCE:
                    begin
                        ctrl.adv_start = !stat.rows_zero;
                        ctrl.gen_inc   = stat.rows_zero;
                    end
                    default:
                        ctrl.rd_req = 1'b0;
                endcase
            end
            lge_pkg::S_WR_WAIT:
            begin
                ctrl.wr_cell = 1'b1;
            end
            lge_pkg::S_RD_WAIT:
            begin
                ctrl.cap_cell = 1'b1;
            end
            lge_pkg::S_ADV:
            begin
                ctrl.adv_step = 1'b1;
                ctrl.gen_inc  = stat.adv_last;
            end
            lge_pkg::S_FINISH:
            begin
                ctrl.rsp_load = stat.rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- hw/rtl/lge_datapath.sv -----
// ----------------------------------------------------------------------------
// lge_datapath
// Grid row memory, three-row window with per-column rule, config and result.
// ----------------------------------------------------------------------------
module lge_datapath #(
    parameter int MAX_ROWS = lge_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lge_pkg::MAX_COLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lge_pkg::lge_req_t               req_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [lge_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lge_pkg::AREA_W-1:0]      cfg_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output lge_pkg::lge_rsp_t               rsp_data,
    input  lge_pkg::lge_ctrl_t              ctrl,
    output lge_pkg::lge_stat_t              stat
);

    localparam int AW  = $clog2(MAX_ROWS);
    localparam int RCW = ($clog2(MAX_ROWS + 1) > lge_pkg::AREA_W) ?
                         $clog2(MAX_ROWS + 1) : lge_pkg::AREA_W;
    localparam int CW  = ($clog2(MAX_COLS + 1) > lge_pkg::AREA_W) ?
                         $clog2(MAX_COLS + 1) : lge_pkg::AREA_W;
    localparam int TW  = RCW + 1;

    logic [lge_pkg::AREA_W-1:0] rows_reg;
    logic [lge_pkg::AREA_W-1:0] cols_reg;
    lge_pkg::lge_req_t          item_reg;
    logic                       cell_reg;
    logic [lge_pkg::GEN_W-1:0]  gen_reg;
    logic [TW-1:0]              step_reg;
    logic [MAX_COLS-1:0]        up_reg;
    logic [MAX_COLS-1:0]        mid_reg;
    logic [MAX_ROWS-1:0]        row_ok_reg;
    logic                       rd_ok_reg;
    logic                       rsp_valid_reg;
    lge_pkg::lge_rsp_t          rsp_data_reg;

    logic [RCW-1:0]      rows_ext;
    logic [CW-1:0]       cols_ext;
    logic [RCW-1:0]      eff_rows;
    logic [CW-1:0]       eff_cols;
    logic [RCW-1:0]      row_ext;
    logic [CW-1:0]       col_ext;
    logic [AW-1:0]       row_addr;
    logic [MAX_COLS-1:0] col_mask;
    logic [MAX_COLS-1:0] col_sel;
    logic [TW-1:0]       step_m2;
    logic                step_rd;
    logic                step_wr;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [MAX_COLS-1:0] ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [MAX_COLS-1:0] ram_rd_data;
    logic [MAX_COLS-1:0] rd_row;
    logic [MAX_COLS-1:0] cell_row;
    logic [MAX_COLS-1:0] next_row;
    logic                rsp_free;

    assign rows_ext = RCW'(rows_reg);
    assign cols_ext = CW'(cols_reg);
    assign eff_rows = (rows_ext > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : rows_ext;
    assign eff_cols = (cols_ext > CW'(MAX_COLS)) ? CW'(MAX_COLS) : cols_ext;
    assign row_ext  = RCW'(item_reg.row);
    assign col_ext  = CW'(item_reg.col);
    assign row_addr = row_ext[AW-1:0];
    assign step_m2  = step_reg - TW'(2);
    assign step_rd  = step_reg < TW'(eff_rows);
    assign step_wr  = step_reg >= TW'(2);

    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_mask[c] = CW'(c) < eff_cols;
            col_sel[c]  = CW'(c) == col_ext;
        end
    end

    assign rd_row   = rd_ok_reg ? ram_rd_data : '0;
    assign cell_row = (rd_row & ~col_sel) | (col_sel & {MAX_COLS{item_reg.cell_in}});

    always_comb
    begin
        logic [MAX_COLS+1:0] up_p;
        logic [MAX_COLS+1:0] mid_p;
        logic [MAX_COLS+1:0] dn_p;
        logic [3:0]          cnt;
        up_p  = {1'b0, up_reg & col_mask, 1'b0};
        mid_p = {1'b0, mid_reg & col_mask, 1'b0};
        dn_p  = {1'b0, rd_row & col_mask, 1'b0};
        for (int c = 0; c < MAX_COLS; c++)
        begin
            cnt = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
                + 4'(mid_p[c]) + 4'(mid_p[c+2])
                + 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
            if (!col_mask[c])
            begin
                next_row[c] = mid_reg[c];
            end
            else
            begin
                next_row[c] = (cnt == 4'd3) || ((cnt == 4'd2) && mid_reg[c]);
            end
        end
    end

    assign ram_rd_en   = ctrl.rd_req || (ctrl.adv_step && step_rd);
    assign ram_rd_addr = ctrl.adv_step ? step_reg[AW-1:0] : row_addr;
    assign ram_wr_en   = ctrl.wr_cell || (ctrl.adv_step && step_wr);
    assign ram_wr_addr = ctrl.adv_step ? step_m2[AW-1:0] : row_addr;
    assign ram_wr_data = ctrl.adv_step ? next_row : cell_row;

    lge_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= lge_pkg::ROWS_RESET;
            cols_reg      <= lge_pkg::COLS_RESET;
            gen_reg       <= '0;
            row_ok_reg    <= '0;
            rd_ok_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    lge_pkg::CFG_ACTIVE_ROWS: rows_reg <= cfg_data;
                    lge_pkg::CFG_ACTIVE_COLS: cols_reg <= cfg_data;
                    default:                  rows_reg <= rows_reg;
                endcase
            end
            if (ctrl.gen_inc)
            begin
                gen_reg <= gen_reg + 1'b1;
            end
            if (ram_wr_en)
            begin
                row_ok_reg[ram_wr_addr] <= 1'b1;
            end
            rd_ok_reg <= ram_rd_en && row_ok_reg[ram_rd_addr];
            if (ctrl.adv_start)
            begin
                step_reg <= '0;
            end
            else if (ctrl.adv_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (ctrl.rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            item_reg <= req_data;
            cell_reg <= 1'b0;
        end
        else if (ctrl.cap_cell)
        begin
            cell_reg <= |(rd_row & col_sel);
        end
        if (ctrl.adv_start)
        begin
            up_reg  <= '0;
            mid_reg <= '0;
        end
        else if (ctrl.adv_step && (step_reg != '0))
        begin
            up_reg  <= mid_reg;
            mid_reg <= rd_row;
        end
        if (ctrl.rsp_load)
        begin
            rsp_data_reg.cell_out   <= cell_reg;
            rsp_data_reg.generation <= gen_reg;
        end
    end

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    assign stat.cmd       = item_reg.cmd;
    assign stat.in_area   = (row_ext < eff_rows) && (col_ext < eff_cols);
    assign stat.rows_zero = eff_rows == '0;
    assign stat.adv_last  = step_reg == (TW'(eff_rows) + TW'(1));
    assign stat.rsp_free  = rsp_free;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// ----- hw/rtl/life_grid_generation_engine_unit.sv -----
// ----------------------------------------------------------------------------
// life_grid_generation_engine_unit
// Conway B3/S23 cell grid with dead border: cell write, cell read, advance.
// ----------------------------------------------------------------------------
// One request beat is taken at a time and gives one response beat. A cell
// write or read inside the area goes from dispatch through a wait state to
// finish; outside the area or for the spare code it goes from dispatch
// straight to finish. An advance steps the effective rows through the advance
// state (skipped when the area has no rows): the grid sits in a row-wide RAM
// that streams one row read and one row written per cycle through a three-row
// window. Grid rows clear at reset through per-row valid flags, so no
// clearing pass is needed. A response waiting on rsp_stall holds in the
// output register; the next request is taken meanwhile. Write the area
// registers only while the block is idle.
module life_grid_generation_engine_unit #(
    parameter int MAX_ROWS = lge_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lge_pkg::MAX_COLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  lge_pkg::lge_req_t             req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output lge_pkg::lge_rsp_t             rsp_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lge_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lge_pkg::AREA_W-1:0]    cfg_data
);

    lge_pkg::lge_ctrl_t ctrl;
    lge_pkg::lge_stat_t stat;

    assign cfg_ready = 1'b1;

    lge_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    lge_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .ctrl      (ctrl),
        .stat      (stat)
    );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the life grid generation engine. Command beats (cell write,
// cell read, advance, spare code) go in under random gaps and response
// stalls. A bench-side copy of the grid and generation counter predicts every
// response. Cell values and counts are checked in order. The area registers
// are swept through empty, single-line, full-size and over-range settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         GRID_N    = 64;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic                          clk;
    logic                          rst_n;
    logic                          req_valid;
    logic                          req_stall;
    lge_pkg::lge_req_t             req_data;
    logic                          rsp_valid;
    logic                          rsp_stall;
    lge_pkg::lge_rsp_t             rsp_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [lge_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lge_pkg::AREA_W-1:0]    cfg_data;

    bit [GRID_N-1:0]          model_grid [GRID_N];
    bit [lge_pkg::GEN_W-1:0]  model_gen;
    bit [lge_pkg::AREA_W-1:0] area_rows;
    bit [lge_pkg::AREA_W-1:0] area_cols;
    lge_pkg::lge_rsp_t        pending_rsp [$];
    bit                       calm;
    int                       errors;
    int                       n_items;
    int                       n_adv;
    int                       n_reads;
    int                       n_cfg;

    life_grid_generation_engine_unit #(
        .MAX_ROWS (GRID_N),
        .MAX_COLS (GRID_N)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int used_rows();
        return (area_rows > GRID_N) ? GRID_N : int'(area_rows);
    endfunction

    function automatic int used_cols();
        return (area_cols > GRID_N) ? GRID_N : int'(area_cols);
    endfunction

    function automatic void step_generation();
        bit [GRID_N-1:0] nxt [GRID_N];
        int nr;
        int nc;
        int cnt;
        nr  = used_rows();
        nc  = used_cols();
        nxt = model_grid;
        for (int r = 0; r < nr; r++)
        begin
            for (int c = 0; c < nc; c++)
            begin
                cnt = 0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        if (!(dr == 0 && dc == 0) && r + dr >= 0 && r + dr < nr &&
                            c + dc >= 0 && c + dc < nc)
                        begin
                            cnt += model_grid[r + dr][c + dc];
                        end
                    end
                end
                if (cnt == 3)
                begin
                    nxt[r][c] = 1'b1;
                end
                else if (cnt != 2)
                begin
                    nxt[r][c] = 1'b0;
                end
            end
        end
        model_grid = nxt;
        model_gen  = model_gen + 1;
    endfunction

    function automatic lge_pkg::lge_rsp_t apply_command(lge_pkg::lge_req_t item);
        lge_pkg::lge_rsp_t rsp;
        bit                in_area;
        in_area      = (item.row < used_rows()) && (item.col < used_cols());
        rsp.cell_out = 1'b0;
        case (item.cmd)
            lge_pkg::CMD_WRITE:
            begin
                if (in_area)
                begin
                    model_grid[item.row][item.col] = item.cell_in;
                end
            end
            lge_pkg::CMD_ADVANCE:
            begin
                step_generation();
            end
            lge_pkg::CMD_READ:
            begin
                if (in_area)
                begin
                    rsp.cell_out = model_grid[item.row][item.col];
                end
            end
            default:
            begin
            end
        endcase
        rsp.generation = model_gen;
        return rsp;
    endfunction

    function automatic lge_pkg::lge_req_t make_cmd(logic [1:0] cmd, int row, int col,
                                                   bit value);
        lge_pkg::lge_req_t item;
        item.cmd     = cmd;
        item.row     = row[5:0];
        item.col     = col[5:0];
        item.cell_in = value;
        return item;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $time, what);
        errors++;
    endtask

    task automatic send_cmd(lge_pkg::lge_req_t item);
        int gap;
        gap = calm ? 0 : int'($urandom_range(0, 3));
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= item;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        pending_rsp.push_back(apply_command(item));
        n_items++;
        if (item.cmd == lge_pkg::CMD_ADVANCE)
        begin
            n_adv++;
        end
        if (item.cmd == lge_pkg::CMD_READ)
        begin
            n_reads++;
        end
    endtask

    // drop the request side and hold until every response beat is back
    task automatic drain_responses();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_area_reg(logic [lge_pkg::CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[lge_pkg::AREA_W-1:0];
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == lge_pkg::CFG_ACTIVE_ROWS)
        begin
            area_rows = value[lge_pkg::AREA_W-1:0];
        end
        else
        begin
            area_cols = value[lge_pkg::AREA_W-1:0];
        end
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_area(int rows, int cols);
        drain_responses();
        if ($urandom_range(0, 1))
        begin
            write_area_reg(lge_pkg::CFG_ACTIVE_ROWS, rows);
            write_area_reg(lge_pkg::CFG_ACTIVE_COLS, cols);
        end
        else
        begin
            write_area_reg(lge_pkg::CFG_ACTIVE_COLS, cols);
            write_area_reg(lge_pkg::CFG_ACTIVE_ROWS, rows);
        end
    endtask

    task automatic test_cell_access();
        send_cmd(make_cmd(lge_pkg::CMD_WRITE, 0, 0, 1'b1));
        send_cmd(make_cmd(lge_pkg::CMD_WRITE, 49, 49, 1'b1));
        send_cmd(make_cmd(lge_pkg::CMD_WRITE, 50, 0, 1'b1));
        send_cmd(make_cmd(lge_pkg::CMD_WRITE, 0, 50, 1'b1));
        send_cmd(make_cmd(lge_pkg::CMD_WRITE, 63, 63, 1'b1));
        send_cmd(make_cmd(lge_pkg::CMD_READ, 0, 0, 1'b0));
        send_cmd(make_cmd(lge_pkg::CMD_READ, 49, 49, 1'b0));
        send_cmd(make_cmd(lge_pkg::CMD_READ, 50, 0, 1'b1));
        send_cmd(make_cmd(lge_pkg::CMD_READ, 63, 63, 1'b0));
        send_cmd(make_cmd(CMD_SPARE, 63, 63, 1'b1));
        send_cmd(make_cmd(lge_pkg::CMD_WRITE, 0, 0, 1'b0));
        send_cmd(make_cmd(lge_pkg::CMD_READ, 0, 0, 1'b0));
    endtask

    task automatic test_area_clamp();
        set_area(127, 127);
        send_cmd(make_cmd(lge_pkg::CMD_WRITE, 63, 63, 1'b1));
        send_cmd(make_cmd(lge_pkg::CMD_WRITE, 62, 63, 1'b1));
        send_cmd(make_cmd(lge_pkg::CMD_WRITE, 63, 62, 1'b1));
        send_cmd(make_cmd(lge_pkg::CMD_ADVANCE, 0, 0, 1'b0));
        send_cmd(make_cmd(lge_pkg::CMD_READ, 62, 62, 1'b0));
        send_cmd(make_cmd(lge_pkg::CMD_READ, 63, 63, 1'b0));
    endtask

    task automatic test_empty_area();
        set_area(0, 0);
        send_cmd(make_cmd(lge_pkg::CMD_WRITE, 5, 5, 1'b1));
        send_cmd(make_cmd(lge_pkg::CMD_READ, 63, 63, 1'b0));
        send_cmd(make_cmd(lge_pkg::CMD_ADVANCE, 0, 0, 1'b0));
        send_cmd(make_cmd(lge_pkg::CMD_READ, 5, 5, 1'b0));
        set_area(64, 64);
        send_cmd(make_cmd(lge_pkg::CMD_READ, 63, 63, 1'b0));
        send_cmd(make_cmd(lge_pkg::CMD_READ, 5, 5, 1'b0));
    endtask

    task automatic test_random();
        int rows_pick [8] = '{1, 64, 3, 127, 0, 8, 64, 12};
        int cols_pick [8] = '{64, 1, 3, 127, 5, 0, 64, 12};
        int nr;
        int nc;
        int wr0;
        int wc0;
        int wh;
        int ww;
        int k;
        int row;
        int col;
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase < 8)
            begin
                set_area(rows_pick[phase], cols_pick[phase]);
            end
            else
            begin
                set_area($urandom_range(0, 127), $urandom_range(0, 127));
            end
            calm = (phase % 4 == 3);
            nr   = used_rows();
            nc   = used_cols();
            wh   = (nr < 8) ? nr : 8;
            ww   = (nc < 8) ? nc : 8;
            wr0  = $urandom_range(0, 1) ? nr - wh : $urandom_range(0, nr - wh);
            wc0  = $urandom_range(0, 1) ? nc - ww : $urandom_range(0, nc - ww);
            for (int n = 0; n < 96; n++)
            begin
                if (phase == 2 && n == 48)
                begin
                    drain_responses();
                end
                k   = $urandom_range(0, 99);
                row = $urandom_range(0, 63);
                col = $urandom_range(0, 63);
                if (nr > 0 && nc > 0 && k < 85)
                begin
                    if (k < 55 || $urandom_range(0, 2) != 0)
                    begin
                        row = wr0 + $urandom_range(0, wh - 1);
                        col = wc0 + $urandom_range(0, ww - 1);
                    end
                    else
                    begin
                        row = $urandom_range(0, nr - 1);
                        col = $urandom_range(0, nc - 1);
                    end
                end
                if (k < 40)
                begin
                    send_cmd(make_cmd(lge_pkg::CMD_WRITE, row, col,
                                      1'($urandom_range(0, 1))));
                end
                else if (k < 55)
                begin
                    send_cmd(make_cmd(lge_pkg::CMD_ADVANCE, row, col,
                                      1'($urandom_range(0, 1))));
                end
                else if (k < 85)
                begin
                    send_cmd(make_cmd(lge_pkg::CMD_READ, row, col,
                                      1'($urandom_range(0, 1))));
                end
                else if (k < 95)
                begin
                    send_cmd(make_cmd($urandom_range(0, 1) ? lge_pkg::CMD_WRITE
                                                           : lge_pkg::CMD_READ,
                                      row, col, 1'($urandom_range(0, 1))));
                end
                else
                begin
                    send_cmd(make_cmd(CMD_SPARE, row, col, 1'($urandom_range(0, 1))));
                end
            end
        end
        calm = 1'b0;
    endtask

    // response side: stall each beat for a randomly drawn hold, then check it
    initial
    begin
        int                hold;
        lge_pkg::lge_rsp_t want;
        rsp_stall = 1'b0;
        hold      = 0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            begin
                if (pending_rsp.size() == 0)
                begin
                    report_mismatch("response beat with nothing outstanding");
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp_data.cell_out !== want.cell_out)
                    begin
                        report_mismatch($sformatf("cell_out %b, predicted %b",
                                                  rsp_data.cell_out, want.cell_out));
                    end
                    if (rsp_data.generation !== want.generation)
                    begin
                        report_mismatch($sformatf("generation %0d, predicted %0d",
                                                  rsp_data.generation, want.generation));
                    end
                end
                hold = calm ? 0 : int'($urandom_range(0, 3));
            end
            else if (rsp_valid === 1'b1 && hold > 0)
            begin
                hold--;
            end
            @(negedge clk);
            rsp_stall <= (hold > 0);
        end
    end

    initial
    begin
        #10_000_000;
        $display("Timeout: response traffic did not finish");
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;
        errors    = 0;
        n_items   = 0;
        n_adv     = 0;
        n_reads   = 0;
        n_cfg     = 0;
        model_gen = '0;
        area_rows = lge_pkg::ROWS_RESET;
        area_cols = lge_pkg::COLS_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_cell_access();
        test_area_clamp();
        test_empty_area();
        test_random();

        drain_responses();
        repeat (20) @(posedge clk);
        $display("Ran %0d command beats (%0d advances, %0d reads), %0d area register writes",
                 n_items, n_adv, n_reads, n_cfg);
        $display("Areas swept: empty, single line, small, full size and over-range values");
        if (errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
